@@ rtl/srbl_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the sorted region lookup block.
// No dependencies; srbl_front, srbl_back and the top level in rtl/ import this package.
package srbl_pkg;

    localparam int MAX_REGIONS_DEF = 64;
    localparam int KIND_W          = 1;
    localparam int IDX_W           = 6;
    localparam int ADDR_W          = 64;
    localparam int COUNT_W         = 7;

    localparam logic [KIND_W-1:0] KIND_WRITE  = 1'b0;
    localparam logic [KIND_W-1:0] KIND_LOOKUP = 1'b1;

    typedef enum logic [1:0] {
        OP_WRITE,
        OP_DROP,
        OP_LOOKUP
    } t_op;

    typedef struct packed {
        t_op                op;
        logic [IDX_W-1:0]   slot;
        logic [ADDR_W-1:0]  data_a;  // region start, or lookup address
        logic [ADDR_W-1:0]  data_b;  // region end
    } t_cmd;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PROBE,
        ST_CHECK,
        ST_DONE
    } t_state;

endpackage

@@ rtl/srbl_ram.sv @@
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module srbl_ram #(
    parameter int WIDTH = 128,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/srbl_front.sv @@
`timescale 1ns / 1ps
// Front end: accept input beats, classify them into commands, and hold
// them in a two-entry queue for the back end. Depends on srbl_pkg.
module srbl_front #(
    parameter int MAX_REGIONS = srbl_pkg::MAX_REGIONS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [srbl_pkg::KIND_W-1:0]  i_kind,
    input  logic [srbl_pkg::IDX_W-1:0]   i_entry_index,
    input  logic [srbl_pkg::ADDR_W-1:0]  i_region_start,
    input  logic [srbl_pkg::ADDR_W-1:0]  i_region_end,
    input  logic [srbl_pkg::ADDR_W-1:0]  i_address,
    output logic                         o_cmd_valid,
    input  logic                         i_cmd_pop,
    output srbl_pkg::t_cmd               o_cmd
);
    import srbl_pkg::*;

    t_cmd       r_q [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic [1:0] n_cnt;
    t_cmd       cls;
    logic       push;
    logic       pop;

    // Classify: out-of-range write slots are dropped.
    always_comb begin
        cls.slot   = i_entry_index;
        cls.data_b = i_region_end;
        if (i_kind == KIND_LOOKUP) begin
            cls.op     = OP_LOOKUP;
            cls.data_a = i_address;
        end else begin
            cls.data_a = i_region_start;
            if (32'(i_entry_index) < MAX_REGIONS) begin
                cls.op = OP_WRITE;
            end else begin
                cls.op = OP_DROP;
            end
        end
    end

    assign o_in_stall  = (r_cnt == 2'd2);
    assign push        = i_in_valid && !o_in_stall;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign pop         = i_cmd_pop && o_cmd_valid;
    assign o_cmd       = r_q[r_rp];

    always_comb begin
        n_cnt = r_cnt;
        if (push && !pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (pop && !push) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
            if (push) begin
                r_wp <= !r_wp;
            end
            if (pop) begin
                r_rp <= !r_rp;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= cls;
        end
    end

`ifndef ASSERT_OFF
    a_no_overfill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3)
        else $error("queue count out of range");
`endif

endmodule

@@ rtl/srbl_back.sv @@
`timescale 1ns / 1ps
// Back end: execute queued commands against the region RAM. Writes store
// a region; lookups run a binary search, one RAM probe per step.
// Depends on srbl_pkg and srbl_ram.
module srbl_back #(
    parameter int MAX_REGIONS = srbl_pkg::MAX_REGIONS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [srbl_pkg::COUNT_W-1:0]  i_entry_count,
    input  logic                          i_cmd_valid,
    output logic                          o_cmd_pop,
    input  srbl_pkg::t_cmd                i_cmd,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic                          o_hit,
    output logic [srbl_pkg::IDX_W-1:0]    o_region_index
);
    import srbl_pkg::*;

    localparam int AW = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
    localparam int CW = $clog2(MAX_REGIONS + 1);
    localparam int SW = (CW > COUNT_W) ? CW : COUNT_W;

    t_state             r_state, n_state;
    logic [CW-1:0]      r_lo, n_lo;
    logic [CW-1:0]      r_hi, n_hi;
    logic [AW-1:0]      r_mid, n_mid;
    logic [ADDR_W-1:0]  r_addr, n_addr;
    logic               r_hit, n_hit;
    logic [IDX_W-1:0]   r_idx, n_idx;
    logic               r_out_valid, n_out_valid;
    logic               r_out_hit, n_out_hit;
    logic [IDX_W-1:0]   r_out_idx, n_out_idx;

    logic [SW-1:0]          cnt_w;
    logic [CW-1:0]          cnt_sat;
    logic [CW:0]            mid_sum;
    logic [AW-1:0]          mid_c;
    logic                   ram_we;
    logic [2*ADDR_W-1:0]    ram_rdata;
    logic [ADDR_W-1:0]      probe_start;
    logic [ADDR_W-1:0]      probe_end;

    assign cnt_w   = SW'(i_entry_count);
    assign cnt_sat = (cnt_w > SW'(MAX_REGIONS)) ? CW'(MAX_REGIONS) : CW'(cnt_w);
    assign mid_sum = (CW+1)'(r_lo) + (CW+1)'(r_hi) - (CW+1)'(1);
    assign mid_c   = mid_sum[AW:1];

    assign probe_start = ram_rdata[2*ADDR_W-1:ADDR_W];
    assign probe_end   = ram_rdata[ADDR_W-1:0];

    srbl_ram #(
        .WIDTH (2 * ADDR_W),
        .DEPTH (MAX_REGIONS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (AW'(i_cmd.slot)),
        .i_wdata ({i_cmd.data_a, i_cmd.data_b}),
        .i_raddr (mid_c),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_state     = r_state;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_mid       = r_mid;
        n_addr      = r_addr;
        n_hit       = r_hit;
        n_idx       = r_idx;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_hit   = r_out_hit;
        n_out_idx   = r_out_idx;
        o_cmd_pop   = 1'b0;
        ram_we      = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_pop = 1'b1;
                    case (i_cmd.op)
                        OP_WRITE: begin
                            ram_we = 1'b1;
                        end
                        OP_LOOKUP: begin
                            n_lo    = '0;
                            n_hi    = cnt_sat;
                            n_addr  = i_cmd.data_a;
                            n_state = ST_PROBE;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_PROBE: begin
                if (r_lo < r_hi) begin
                    n_mid   = mid_c;
                    n_state = ST_CHECK;
                end else begin
                    n_hit   = 1'b0;
                    n_idx   = '0;
                    n_state = ST_DONE;
                end
            end
            ST_CHECK: begin
                if (r_addr < probe_start) begin
                    n_hi    = CW'(r_mid);
                    n_state = ST_PROBE;
                end else if (r_addr >= probe_end) begin
                    n_lo    = CW'(r_mid) + CW'(1);
                    n_state = ST_PROBE;
                end else begin
                    n_hit   = 1'b1;
                    n_idx   = IDX_W'(r_mid);
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_out_hit   = r_hit;
                    n_out_idx   = r_idx;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lo      <= n_lo;
        r_hi      <= n_hi;
        r_mid     <= n_mid;
        r_addr    <= n_addr;
        r_hit     <= n_hit;
        r_idx     <= n_idx;
        r_out_hit <= n_out_hit;
        r_out_idx <= n_out_idx;
    end

    assign o_out_valid    = r_out_valid;
    assign o_hit          = r_out_hit;
    assign o_region_index = r_out_idx;

`ifndef ASSERT_OFF
    a_window_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_CHECK |-> (r_lo < r_hi) && (CW'(r_mid) < r_hi))
        else $error("probe outside search window");
    a_hi_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != ST_IDLE |-> 32'(r_hi) <= MAX_REGIONS)
        else $error("search bound beyond table");
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out_hit |-> r_out_idx == '0)
        else $error("miss with nonzero region index");
    a_done_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_DONE && (!r_out_valid || !i_out_stall) |=>
            r_out_valid && r_state == ST_IDLE)
        else $error("result not loaded into output register");
`endif

endmodule

@@ rtl/sorted_region_binary_lookup_top.sv @@
`timescale 1ns / 1ps
// Top level of the sorted region lookup block: config register, front end
// queue and back end search engine. Depends on srbl_pkg, srbl_front, srbl_back.
//
// The block holds MAX_REGIONS address regions [start, end) in one RAM and
// answers lookups by binary search over the first entry_count slots (the
// count saturates at MAX_REGIONS). A write beat (kind 0) stores a region and
// gives no result; a write to a slot at or beyond MAX_REGIONS is dropped. A
// lookup beat (kind 1) gives one result beat: hit and the slot index, or
// hit = 0 and index 0. Beats enter a two-entry queue, so the input keeps
// flowing until that queue is full, while the search engine works or the
// output is stalled. Items are carried out one at a time: a write is stored
// as the engine pops it; a lookup is popped, then runs its probes, each one
// RAM read and one compare step, with at most ceil(log2(entry_count + 1))
// probes; the result then waits in ST_DONE until the output register is
// free. The table needs no clearing after reset; slots must be written
// before a lookup can probe them. Write entry_count only while idle.
module sorted_region_binary_lookup_top #(
    parameter int MAX_REGIONS = srbl_pkg::MAX_REGIONS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // config register
    input  logic                          i_cfg_we,
    input  logic [srbl_pkg::COUNT_W-1:0]  i_cfg_wdata,
    // input channel
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [srbl_pkg::KIND_W-1:0]   i_kind,
    input  logic [srbl_pkg::IDX_W-1:0]    i_entry_index,
    input  logic [srbl_pkg::ADDR_W-1:0]   i_region_start,
    input  logic [srbl_pkg::ADDR_W-1:0]   i_region_end,
    input  logic [srbl_pkg::ADDR_W-1:0]   i_address,
    // result channel
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic                          o_hit,
    output logic [srbl_pkg::IDX_W-1:0]    o_region_index
);
    import srbl_pkg::*;

    logic [COUNT_W-1:0] r_entry_count;
    logic               cmd_valid;
    logic               cmd_pop;
    t_cmd               cmd;

    // Hold the entry count; software must write it only while idle, and this block does not enforce that.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_count <= '0;
        end else if (i_cfg_we) begin
            r_entry_count <= i_cfg_wdata;
        end
    end

    // Front: accept and classify beats, queue them.
    srbl_front #(
        .MAX_REGIONS (MAX_REGIONS)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_kind         (i_kind),
        .i_entry_index  (i_entry_index),
        .i_region_start (i_region_start),
        .i_region_end   (i_region_end),
        .i_address      (i_address),
        .o_cmd_valid    (cmd_valid),
        .i_cmd_pop      (cmd_pop),
        .o_cmd          (cmd)
    );

    // Back: store regions, run searches, drive the result register.
    srbl_back #(
        .MAX_REGIONS (MAX_REGIONS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_entry_count  (r_entry_count),
        .i_cmd_valid    (cmd_valid),
        .o_cmd_pop      (cmd_pop),
        .i_cmd          (cmd),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_hit          (o_hit),
        .o_region_index (o_region_index)
    );

endmodule

@@ tb/sv/sorted_region_binary_lookup_top_tb.sv @@
`timescale 1ns / 1ps
// Self-checking bench for sorted_region_binary_lookup_top: region writes and
// address lookups with a binary-search predictor. Depends on srbl_pkg and the RTL.
module sorted_region_binary_lookup_top_tb;
    import srbl_pkg::*;

    localparam int  N_SLOTS     = MAX_REGIONS_DEF;
    localparam int  ITEM_GOAL   = 750;
    // Settle time before a register write or the end; the input queue holds
    // two beats.
    localparam int  SETTLE      = 60;
    localparam int  CYCLE_LIMIT = 400000;
    localparam int  HOLD_CYCLES = 300;

    typedef struct {
        logic [KIND_W-1:0] op_kind;
        logic [IDX_W-1:0]  slot;
        logic [ADDR_W-1:0] lo;
        logic [ADDR_W-1:0] hi;
        logic [ADDR_W-1:0] addr;
    } t_region_beat;

    typedef struct {
        bit                found;
        logic [IDX_W-1:0]  slot;
        logic [ADDR_W-1:0] addr;
    } t_lookup_answer;

    // DUT-facing signals; the driven ones are known from time zero
    logic                clk          = 1'b0;
    logic                rst_n        = 1'b0;
    logic                cfg_we       = 1'b0;
    logic [COUNT_W-1:0]  cfg_wdata    = '0;
    logic                in_valid     = 1'b0;
    logic                in_stall;
    logic [KIND_W-1:0]   kind         = KIND_WRITE;
    logic [IDX_W-1:0]    entry_index  = '0;
    logic [ADDR_W-1:0]   region_start = '0;
    logic [ADDR_W-1:0]   region_end   = '0;
    logic [ADDR_W-1:0]   address      = '0;
    logic                out_valid;
    logic                out_stall    = 1'b0;
    logic                hit;
    logic [IDX_W-1:0]    region_index;

    // Predictor state: the region table as the block should hold it, and the
    // search count. The plan copy runs ahead of the block and steers stimulus.
    logic [ADDR_W-1:0]   table_lo [N_SLOTS];
    logic [ADDR_W-1:0]   table_hi [N_SLOTS];
    logic [ADDR_W-1:0]   plan_lo  [N_SLOTS];
    logic [ADDR_W-1:0]   plan_hi  [N_SLOTS];
    int unsigned         region_count = 0;

    t_region_beat        pending_beats_q[$];
    t_lookup_answer      lookup_answers_q[$];

    int unsigned         beats_taken  = 0;
    int unsigned         backlog      = 0;
    int unsigned         items_queued = 0;
    int unsigned         mismatches   = 0;
    int unsigned         cycle_n      = 0;
    int unsigned         holdoff_left = 0;
    bit                  holdoff_done = 1'b0;

    // Stretch of beats in which neither side idles or stalls at random
    wire calm = (beats_taken >= 200) && (beats_taken < 350);

    sorted_region_binary_lookup_top u_top (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_wdata    (cfg_wdata),
        .i_in_valid     (in_valid),
        .o_in_stall     (in_stall),
        .i_kind         (kind),
        .i_entry_index  (entry_index),
        .i_region_start (region_start),
        .i_region_end   (region_end),
        .i_address      (address),
        .o_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .o_hit          (hit),
        .o_region_index (region_index)
    );

    always #5 clk = ~clk;

    function automatic logic [ADDR_W-1:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Binary search over the first region_count slots (saturated at the table
    // size). The upper bound is exclusive, so the search cannot run below
    // slot 0; it just ends with a miss.
    function automatic t_lookup_answer search_regions(input logic [ADDR_W-1:0] addr);
        t_lookup_answer ans;
        int             lo_i;
        int             hi_i;
        int             mid;
        ans.found = 1'b0;
        ans.slot  = '0;
        ans.addr  = addr;
        lo_i = 0;
        hi_i = (region_count > N_SLOTS) ? N_SLOTS : int'(region_count);
        while (lo_i < hi_i) begin
            mid = (lo_i + hi_i - 1) / 2;
            if (addr < table_lo[mid]) begin
                hi_i = mid;
            end else if (addr >= table_hi[mid]) begin
                lo_i = mid + 1;
            end else begin
                ans.found = 1'b1;
                ans.slot  = mid[IDX_W-1:0];
                break;
            end
        end
        return ans;
    endfunction

    task automatic flag_mismatch(input string what);
        $display("MISMATCH @%0t: %s", $realtime, what);
        mismatches++;
    endtask

    // Driver: advance to the next pending beat once the current one is taken.
    // Each accepted beat goes through the predictor right here, in order.
    always @(posedge clk) begin : beat_driver
        t_region_beat nxt;
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !in_stall) begin
                beats_taken <= beats_taken + 1;
                if (kind == KIND_WRITE) begin
                    table_lo[entry_index] = region_start;
                    table_hi[entry_index] = region_end;
                end else begin
                    lookup_answers_q.push_back(search_regions(address));
                end
            end
            if (!in_valid || !in_stall) begin
                if (pending_beats_q.size() != 0 && (calm || $urandom_range(99) >= 32)) begin
                    nxt = pending_beats_q.pop_front();
                    in_valid     <= 1'b1;
                    kind         <= nxt.op_kind;
                    entry_index  <= nxt.slot;
                    region_start <= nxt.lo;
                    region_end   <= nxt.hi;
                    address      <= nxt.addr;
                end else begin
                    in_valid <= 1'b0;
                end
            end
            backlog <= pending_beats_q.size();
        end
    end

    // Long receiver hold-off, once, while plenty of beats are still waiting,
    // so the input queue fills and the block pushes back on the sender.
    always @(posedge clk) begin : holdoff_counter
        if (!holdoff_done && !calm && beats_taken >= 450 && backlog >= 8) begin
            holdoff_left <= HOLD_CYCLES;
            holdoff_done <= 1'b1;
        end else if (holdoff_left != 0) begin
            holdoff_left <= holdoff_left - 1;
        end
    end

    always @(posedge clk) begin : result_stall
        out_stall <= rst_n && (holdoff_left != 0 || (!calm && $urandom_range(99) < 32));
    end

    // Monitor: each result beat is checked against the oldest open lookup
    always @(posedge clk) begin : result_check
        t_lookup_answer want;
        if (rst_n && out_valid && !out_stall) begin
            if (lookup_answers_q.size() == 0) begin
                flag_mismatch($sformatf("result beat hit=%0b idx=%0d with no lookup open",
                                        hit, region_index));
            end else begin
                want = lookup_answers_q.pop_front();
                if (hit !== want.found)
                    flag_mismatch($sformatf("addr %h: hit %b, want %b",
                                            want.addr, hit, want.found));
                if (region_index !== want.slot)
                    flag_mismatch($sformatf("addr %h: region_index %0d, want %0d",
                                            want.addr, region_index, want.slot));
            end
        end
    end

    always @(posedge clk) begin : run_limit
        cycle_n <= cycle_n + 1;
        if (cycle_n >= CYCLE_LIMIT) begin
            $display("sorted_region_binary_lookup_top test failed");
            $finish;
        end
    end

    // ---------------------------------------------------------------- stimulus

    task automatic queue_write(input int slot, input logic [ADDR_W-1:0] lo,
                               input logic [ADDR_W-1:0] hi);
        t_region_beat b;
        b.op_kind = KIND_WRITE;
        b.slot    = slot[IDX_W-1:0];
        b.lo      = lo;
        b.hi      = hi;
        b.addr    = rand64();   // ignored on a write
        plan_lo[slot] = lo;
        plan_hi[slot] = hi;
        pending_beats_q.push_back(b);
        items_queued++;
    endtask

    task automatic queue_lookup(input logic [ADDR_W-1:0] addr);
        t_region_beat b;
        b.op_kind = KIND_LOOKUP;
        b.slot    = IDX_W'($urandom);   // region fields are ignored on a lookup
        b.lo      = rand64();
        b.hi      = rand64();
        b.addr    = addr;
        pending_beats_q.push_back(b);
        items_queued++;
    endtask

    // Let the block drain: nothing pending, nothing in flight, then settle.
    task automatic wait_idle();
        do @(negedge clk);
        while (pending_beats_q.size() != 0 || in_valid || lookup_answers_q.size() != 0);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic set_region_count(input int unsigned n);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= n[COUNT_W-1:0];
        @(posedge clk);
        cfg_we    <= 1'b0;
        region_count = n;
        @(negedge clk);
    endtask

    function automatic logic [ADDR_W-1:0] pick_base(input int shift);
        logic [ADDR_W-1:0] span;
        if ($urandom_range(3) == 0)
            return '0;
        span = 64'd64 << shift;
        return rand64() % (~span + 64'd1);
    endfunction

    // Sorted layout: slot i lives in its own 2^shift window above base, with
    // the odd empty or inverted region mixed in.
    task automatic lay_sorted(input int shift, input logic [ADDR_W-1:0] base);
        logic [ADDR_W-1:0] half;
        logic [ADDR_W-1:0] lo;
        logic [ADDR_W-1:0] hi;
        int                r;
        half = 64'd1 << (shift - 1);
        for (int i = 0; i < N_SLOTS; i++) begin
            lo = base + (64'(i) << shift) + rand64() % half;
            r  = $urandom_range(19);
            if (r < 2)
                hi = lo;            // empty
            else if (r == 2)
                hi = lo >> 1;       // inverted
            else
                hi = lo + 64'd1 + rand64() % half;
            queue_write(i, lo, hi);
        end
    endtask

    // Unsorted layout: anything goes, the search just follows its probes
    task automatic lay_scrambled();
        bit narrow;
        narrow = $urandom_range(1);
        for (int i = 0; i < N_SLOTS; i++) begin
            if (narrow)
                queue_write(i, 64'($urandom_range(255)), 64'($urandom_range(255)));
            else
                queue_write(i, rand64(), rand64());
        end
    endtask

    // Address aimed at a region edge or interior, or a wild one
    function automatic logic [ADDR_W-1:0] pick_address();
        int                top;
        int                j;
        logic [ADDR_W-1:0] width;
        top = (region_count == 0) ? N_SLOTS : ((region_count > N_SLOTS) ? N_SLOTS
                                                                        : region_count);
        j = $urandom_range(top - 1);
        width = plan_hi[j] - plan_lo[j];
        case ($urandom_range(9))
            0:       return rand64();
            1:       return $urandom_range(1) ? '1 : '0;
            2:       return plan_lo[j];
            3:       return plan_lo[j] - 64'd1;
            4:       return plan_hi[j];
            5:       return plan_hi[j] - 64'd1;
            default: return (plan_hi[j] > plan_lo[j]) ? plan_lo[j] + rand64() % width
                                                       : plan_lo[j];
        endcase
    endfunction

    // Rewrite one slot: mostly shrink it in place so the order holds,
    // sometimes drop garbage into it
    task automatic queue_rewrite();
        int                j;
        logic [ADDR_W-1:0] width;
        j = $urandom_range(N_SLOTS - 1);
        width = plan_hi[j] - plan_lo[j];
        if ($urandom_range(9) < 7 && plan_hi[j] > plan_lo[j])
            queue_write(j, plan_lo[j], plan_lo[j] + rand64() % (width + 64'd1));
        else
            queue_write(j, rand64(), rand64());
    endtask

    initial begin : stimulus
        int unsigned n_items;
        int          pick;
        int          shift;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Zero count after reset: every lookup misses, nothing is probed
        queue_lookup(rand64());
        queue_lookup('1);

        // Fill the whole table before any lookup can probe it
        lay_sorted(8, 64'd256);
        queue_write(5, plan_lo[5], plan_lo[5]);             // empty region
        queue_write(9, plan_lo[9], plan_lo[9] - 64'd1);     // inverted region
        wait_idle();

        // Count above the table size saturates to the full table
        set_region_count(127);
        queue_lookup('0);
        queue_lookup(plan_lo[0] - 64'd1);   // below the table: the search ends with a miss at the low end
        queue_lookup(plan_lo[0]);
        queue_lookup(plan_lo[31]);
        queue_lookup(plan_lo[5]);           // lands on the empty region
        queue_lookup(plan_lo[9]);           // lands on the inverted region
        queue_lookup(plan_lo[63]);
        queue_lookup(plan_hi[63] - 64'd1);
        queue_lookup(plan_hi[63]);          // just past the top
        queue_lookup('1);
        wait_idle();

        set_region_count(1);
        queue_lookup(plan_lo[0]);
        queue_lookup(plan_lo[1]);           // outside the searched range
        wait_idle();
        set_region_count(N_SLOTS);
        queue_lookup(plan_hi[63] - 64'd1);
        queue_lookup(plan_lo[32]);

        // Random phases: new count, sometimes a new layout, then a burst of
        // lookups with the odd slot rewrite mixed in
        while (items_queued < ITEM_GOAL) begin
            wait_idle();
            case ($urandom_range(9))
                0:       set_region_count(0);
                1:       set_region_count(1);
                2:       set_region_count(N_SLOTS);
                3:       set_region_count($urandom_range(N_SLOTS + 1, 127));
                default: set_region_count($urandom_range(2, N_SLOTS - 1));
            endcase
            pick = $urandom_range(7);
            if (pick == 0) begin
                lay_scrambled();
            end else if (pick < 3) begin
                shift = $urandom_range(3, 57);
                lay_sorted(shift, pick_base(shift));
            end
            n_items = $urandom_range(30, 70);
            repeat (n_items) begin
                if ($urandom_range(99) < 15)
                    queue_rewrite();
                else
                    queue_lookup(pick_address());
            end
        end

        wait_idle();
        if (lookup_answers_q.size() != 0)
            flag_mismatch($sformatf("%0d lookups never answered", lookup_answers_q.size()));
        if (mismatches == 0) begin
            $display("sorted_region_binary_lookup_top test passed");
        end else begin
            $display("sorted_region_binary_lookup_top test failed");
        end
        $finish;
    end

endmodule

@@ sim.f @@
rtl/srbl_pkg.sv
rtl/srbl_ram.sv
rtl/srbl_front.sv
rtl/srbl_back.sv
rtl/sorted_region_binary_lookup_top.sv
tb/sv/sorted_region_binary_lookup_top_tb.sv
